@@ sv/assert_macros.svh @@
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, ignored while in reset
`define ASSERT_IMP(lbl, clk_s, rst_s, pre, con) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (pre) |-> (con)) \
    else $error("assertion failed");

// next-cycle implication, ignored while in reset
`define ASSERT_NXT(lbl, clk_s, rst_s, pre, con) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (pre) |=> (con)) \
    else $error("assertion failed");

// next-cycle implication, checked through reset
`define ASSERT_NXT_ALL(lbl, clk_s, pre, con) \
  lbl: assert property (@(posedge clk_s) (pre) |=> (con)) \
    else $error("assertion failed");

`endif

@@ sv/e2q_pkg.sv @@
// Shared constants and arithmetic helpers for the Euler to quaternion unit
package e2q_pkg;

  localparam int ANGLE_BITS_DEF = 16;
  localparam int OUT_BITS_DEF = 16;
  localparam int TRIG_ITER_DEF = 16;
  localparam int TRIG_ITER_MAX = 32;
  localparam int Q_BITS = 32;
  localparam int Z_BITS = 34;
  localparam logic signed [Z_BITS-1:0] CORDIC_X0 = 34'sd652032874;

  function automatic logic [31:0] atan_val(input int idx);
    logic [31:0] r;
    case (idx)
      0: r = 32'h20000000;
      1: r = 32'h12E4051D;
      2: r = 32'h09FB385B;
      3: r = 32'h051111D4;
      4: r = 32'h028B0D43;
      5: r = 32'h0145D7E1;
      6: r = 32'h00A2F61E;
      7: r = 32'h00517C55;
      8: r = 32'h0028BE53;
      9: r = 32'h00145F2E;
      10: r = 32'h000A2F98;
      11: r = 32'h000517CC;
      12: r = 32'h00028BE6;
      13: r = 32'h000145F3;
      14: r = 32'h0000A2F9;
      15: r = 32'h0000517C;
      16: r = 32'h000028BE;
      17: r = 32'h0000145F;
      18: r = 32'h00000A2F;
      19: r = 32'h00000517;
      20: r = 32'h0000028B;
      21: r = 32'h00000145;
      22: r = 32'h000000A2;
      23: r = 32'h00000051;
      24: r = 32'h00000028;
      25: r = 32'h00000014;
      26: r = 32'h0000000A;
      27: r = 32'h00000005;
      28: r = 32'h00000002;
      29: r = 32'h00000001;
      default: r = 32'h00000000;
    endcase
    return r;
  endfunction

  // Q30 product, rounded half up by floor
  function automatic logic signed [Q_BITS-1:0] mulq(input logic signed [Q_BITS-1:0] a,
                                                    input logic signed [Q_BITS-1:0] b);
    logic signed [2*Q_BITS-1:0] p;
    p = a * b + 64'sd536870912;
    return p[61:30];
  endfunction

endpackage

@@ sv/e2q_cordic.sv @@
// Pipelined rotation CORDIC giving half-angle cosine and sine for three angles
module e2q_cordic import e2q_pkg::*; #(
  parameter int ANGLE_BITS = ANGLE_BITS_DEF,
  parameter int TRIG_ITERATIONS = TRIG_ITER_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  logic [2:0][ANGLE_BITS-1:0] ang,
  output logic out_valid,
  input  logic out_ready,
  output logic [2:0][Q_BITS-1:0] cos_v,
  output logic [2:0][Q_BITS-1:0] sin_v
);

  localparam int N = (TRIG_ITERATIONS > TRIG_ITER_MAX) ? TRIG_ITER_MAX : TRIG_ITERATIONS;

  logic [N-1:0] vld;
  logic [N-1:0] mv;
  logic signed [Z_BITS-1:0] xs [3][N];
  logic signed [Z_BITS-1:0] ys [3][N];
  logic signed [Z_BITS-1:0] zs [3][N];

  assign in_ready = mv[0];
  assign out_valid = vld[N-1];

  genvar i, l;
  generate
    for (i = 0; i < N; i++) begin : g_ctl
      if (i == N - 1) begin : g_last
        assign mv[i] = ~vld[i] | out_ready;
      end else begin : g_mid
        assign mv[i] = ~vld[i] | mv[i+1];
      end
      always_ff @(posedge clk) begin
        if (rst) begin
          vld[i] <= 1'b0;
        end else if (mv[i]) begin
          vld[i] <= (i == 0) ? in_valid : vld[(i == 0) ? 0 : i-1];
        end
      end
    end

    for (l = 0; l < 3; l++) begin : g_lane
      for (i = 0; i < N; i++) begin : g_stg
        logic signed [Z_BITS-1:0] xi, yi, zi, dx, dy, da;
        logic signed [Z_BITS-1:0] x_next, y_next, z_next;
        logic pv;
        if (i == 0) begin : g_src0
          assign xi = CORDIC_X0;
          assign yi = '0;
          assign zi = Z_BITS'(signed'(ang[l])) <<< (32 - ANGLE_BITS);
          assign pv = in_valid;
        end else begin : g_srcn
          assign xi = xs[l][i-1];
          assign yi = ys[l][i-1];
          assign zi = zs[l][i-1];
          assign pv = vld[i-1];
        end
        assign dx = yi >>> i;
        assign dy = xi >>> i;
        assign da = signed'({1'b0, atan_val(i), 1'b0});
        always_comb begin
          if (!zi[Z_BITS-1]) begin
            x_next = xi - dx;
            y_next = yi + dy;
            z_next = zi - da;
          end else begin
            x_next = xi + dx;
            y_next = yi - dy;
            z_next = zi + da;
          end
        end
        always_ff @(posedge clk) begin
          if (mv[i] && pv) begin
            xs[l][i] <= x_next;
            ys[l][i] <= y_next;
            zs[l][i] <= z_next;
          end
        end
      end
      assign cos_v[l] = xs[l][N-1][Q_BITS-1:0];
      assign sin_v[l] = ys[l][N-1][Q_BITS-1:0];
    end
  endgenerate

endmodule

@@ sv/e2q_combine.sv @@
// Quaternion product stages with rounding and saturation to the output format
module e2q_combine import e2q_pkg::*; #(
  parameter int OUT_BITS = OUT_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  logic [2:0][Q_BITS-1:0] cos_v,
  input  logic [2:0][Q_BITS-1:0] sin_v,
  output logic out_valid,
  input  logic out_ready,
  output logic [3:0][OUT_BITS-1:0] quat
);

  localparam int SH = 31 - OUT_BITS;
  localparam int R_BITS = Q_BITS + 3;

  logic [2:0] vld;
  logic [2:0] mv;

  logic signed [Q_BITS-1:0] srcp, crsp, crcp, srsp, cy1, sy1;
  logic signed [Q_BITS-1:0] t [8];
  logic [3:0][OUT_BITS-1:0] q_next;

  assign mv[2] = ~vld[2] | out_ready;
  assign mv[1] = ~vld[1] | mv[2];
  assign mv[0] = ~vld[0] | mv[1];
  assign in_ready = mv[0];
  assign out_valid = vld[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (mv[0]) vld[0] <= in_valid;
      if (mv[1]) vld[1] <= vld[0];
      if (mv[2]) vld[2] <= vld[1];
    end
  end

  always_ff @(posedge clk) begin
    if (mv[0] && in_valid) begin
      srcp <= mulq(signed'(sin_v[0]), signed'(cos_v[1]));
      crsp <= mulq(signed'(cos_v[0]), signed'(sin_v[1]));
      crcp <= mulq(signed'(cos_v[0]), signed'(cos_v[1]));
      srsp <= mulq(signed'(sin_v[0]), signed'(sin_v[1]));
      cy1 <= signed'(cos_v[2]);
      sy1 <= signed'(sin_v[2]);
    end
  end

  always_ff @(posedge clk) begin
    if (mv[1] && vld[0]) begin
      t[0] <= mulq(srcp, cy1);
      t[1] <= mulq(crsp, sy1);
      t[2] <= mulq(crsp, cy1);
      t[3] <= mulq(srcp, sy1);
      t[4] <= mulq(crcp, sy1);
      t[5] <= mulq(srsp, cy1);
      t[6] <= mulq(crcp, cy1);
      t[7] <= mulq(srsp, sy1);
    end
  end

  logic signed [R_BITS-1:0] sums [4];
  assign sums[0] = R_BITS'(t[0]) - R_BITS'(t[1]);
  assign sums[1] = R_BITS'(t[2]) + R_BITS'(t[3]);
  assign sums[2] = R_BITS'(t[4]) - R_BITS'(t[5]);
  assign sums[3] = R_BITS'(t[6]) + R_BITS'(t[7]);

  localparam logic signed [R_BITS-1:0] HI = R_BITS'((64'sd1 <<< (OUT_BITS - 1)) - 64'sd1);
  localparam logic signed [R_BITS-1:0] LO = R_BITS'(-(64'sd1 <<< (OUT_BITS - 1)));

  genvar k;
  generate
    for (k = 0; k < 4; k++) begin : g_out
      logic signed [R_BITS-1:0] r;
      if (SH > 0) begin : g_rnd
        assign r = (sums[k] + R_BITS'(64'sd1 <<< (SH - 1))) >>> SH;
      end else if (SH == 0) begin : g_eq
        assign r = sums[k];
      end else begin : g_dbl
        assign r = sums[k] <<< 1;
      end
      always_comb begin
        if (r > HI) begin
          q_next[k] = HI[OUT_BITS-1:0];
        end else if (r < LO) begin
          q_next[k] = LO[OUT_BITS-1:0];
        end else begin
          q_next[k] = r[OUT_BITS-1:0];
        end
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (mv[2] && vld[1]) begin
      quat <= q_next;
    end
  end

endmodule

@@ sv/euler_to_quaternion_unit.sv @@
// Euler to quaternion top level: CORDIC pipeline followed by product stages
// Throughput: one item per cycle when out_ready does not stall the output.
// Each CORDIC iteration, each product level and the final rounding step is a stage.
// A stalled output holds its item while empty stages upstream keep filling.
// Synchronous reset clears all stage valid bits; data registers are not reset.
module euler_to_quaternion_unit import e2q_pkg::*; #(
  parameter int ANGLE_BITS = ANGLE_BITS_DEF,
  parameter int OUT_BITS = OUT_BITS_DEF,
  parameter int TRIG_ITERATIONS = TRIG_ITER_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  logic signed [ANGLE_BITS-1:0] roll_angle,
  input  logic signed [ANGLE_BITS-1:0] pitch_angle,
  input  logic signed [ANGLE_BITS-1:0] yaw_angle,
  output logic out_valid,
  input  logic out_ready,
  output logic signed [OUT_BITS-1:0] quat_x,
  output logic signed [OUT_BITS-1:0] quat_y,
  output logic signed [OUT_BITS-1:0] quat_z,
  output logic signed [OUT_BITS-1:0] quat_w
);

  logic [2:0][ANGLE_BITS-1:0] ang;
  logic [2:0][Q_BITS-1:0] cos_v, sin_v;
  logic trig_valid, trig_ready;
  logic [3:0][OUT_BITS-1:0] quat;

  assign ang = {yaw_angle, pitch_angle, roll_angle};

  e2q_cordic #(
    .ANGLE_BITS(ANGLE_BITS),
    .TRIG_ITERATIONS(TRIG_ITERATIONS)
  ) u_cordic (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .ang(ang),
    .out_valid(trig_valid),
    .out_ready(trig_ready),
    .cos_v(cos_v),
    .sin_v(sin_v)
  );

  e2q_combine #(
    .OUT_BITS(OUT_BITS)
  ) u_combine (
    .clk(clk),
    .rst(rst),
    .in_valid(trig_valid),
    .in_ready(trig_ready),
    .cos_v(cos_v),
    .sin_v(sin_v),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .quat(quat)
  );

  assign quat_x = signed'(quat[0]);
  assign quat_y = signed'(quat[1]);
  assign quat_z = signed'(quat[2]);
  assign quat_w = signed'(quat[3]);

endmodule

@@ sv/e2q_checker.sv @@
// Port-level checker for the Euler to quaternion unit, bound to the top level
`include "assert_macros.svh"

module e2q_checker #(
  parameter int OUT_BITS = 16
) (
  input logic clk,
  input logic rst,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic [OUT_BITS-1:0] quat_x,
  input logic [OUT_BITS-1:0] quat_y,
  input logic [OUT_BITS-1:0] quat_z,
  input logic [OUT_BITS-1:0] quat_w
);

  `ASSERT_NXT_ALL(a_rst_clears, clk, rst, !out_valid)
  `ASSERT_IMP(a_empty_ready, clk, rst, !out_valid, in_ready)
  `ASSERT_NXT(a_hold_valid, clk, rst, out_valid && !out_ready, out_valid)
  `ASSERT_NXT(a_hold_data, clk, rst, out_valid && !out_ready, $stable({quat_x, quat_y, quat_z, quat_w}))

endmodule

bind euler_to_quaternion_unit e2q_checker #(.OUT_BITS(OUT_BITS)) u_e2q_checker (
  .clk(clk),
  .rst(rst),
  .in_ready(in_ready),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .quat_x(quat_x),
  .quat_y(quat_y),
  .quat_z(quat_z),
  .quat_w(quat_w)
);
